// ----- rtl/bmps_pkg.sv -----
package bmps_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LIGHT_X = 2'd0;
	localparam logic [1:0] CFG_LIGHT_Y = 2'd1;

	localparam logic [8:0] LIGHT_X_RESET = 9'd160;
	localparam logic [7:0] LIGHT_Y_RESET = 8'd100;

	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 200;

	// Slope coordinates are biased by half of their 0..255 range.
	localparam logic [7:0] COORD_BIAS = 8'd128;

	// Intensity search: k is six bits, the scale is 63 squared.
	localparam int         K_W       = 6;
	localparam logic [5:0] MAX_K     = 6'd63;
	localparam logic [11:0] ENV_SCALE = 12'd3969;
	localparam int         RHS_SHIFT = 14;
	localparam int         LHS_W     = 27;

	// Largest left-hand side that still lies on the light disc.
	localparam logic [LHS_W-1:0] DISC_LHS = LHS_W'(16384 * 3969);

	typedef struct packed {
		logic              on_screen;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
	} slope_t;

endpackage

// ----- rtl/bump_map_pixel_shader_core.sv -----
// Bump-mapped pixel shader with a radial environment light.
//
// The input channel (in_valid / in_stall) carries one pixel per beat: the four
// neighboring height bytes and the screen position. The output channel
// (out_valid / out_stall) returns one intensity beat per pixel, in order.
// The configuration channel (cfg_valid / cfg_ready) writes light_x at index 0
// and light_y at index 1; other indexes are ignored. It is always ready, and
// it should only be written while no pixel is in flight.
//
// Throughput is one pixel per clock while no valid result is stalled. The pipe
// has nine register stages: one stage forms the slope coordinates, two stages
// form the squared radius and scale it, and six stages settle the intensity one
// bit per stage by comparing against a squared complement. out_valid comes
// straight from the valid bit of the last search stage.
//
// Reset clears every stage's valid bit and loads the light registers with
// their defaults. When the receiver stalls a valid result, the whole pipe
// holds in place and in_stall rises, so no beat is lost or repeated; bubbles
// in the pipe keep flowing as long as the output is not stalled.
module bump_map_pixel_shader_core #(
	parameter int SCREEN_WIDTH  = bmps_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bmps_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] height_left,
	input  logic [7:0] height_right,
	input  logic [7:0] height_above,
	input  logic [7:0] height_below,
	input  logic [8:0] pixel_col,
	input  logic [7:0] pixel_row,

	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] intensity,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	logic                        en;
	logic [8:0]                  light_x_q;
	logic [7:0]                  light_y_q;
	logic                        valid_s1;
	bmps_pkg::slope_t            slope_s1;
	logic                        valid_s3;
	logic [bmps_pkg::LHS_W-1:0]  lhs_s3;

	// The pipe advances unless a finished result is being held by the receiver.
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= bmps_pkg::LIGHT_X_RESET;
			light_y_q <= bmps_pkg::LIGHT_Y_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bmps_pkg::CFG_LIGHT_X: light_x_q <= cfg_data;
				bmps_pkg::CFG_LIGHT_Y: light_y_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	bmps_slope #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_slope (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.height_left  (height_left),
		.height_right (height_right),
		.height_above (height_above),
		.height_below (height_below),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.light_x      (light_x_q),
		.light_y      (light_y_q),
		.valid_s1     (valid_s1),
		.slope_s1     (slope_s1)
	);

	bmps_radius u_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.slope_s1 (slope_s1),
		.valid_s3 (valid_s3),
		.lhs_s3   (lhs_s3)
	);

	bmps_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s3  (valid_s3),
		.lhs_s3    (lhs_s3),
		.out_valid (out_valid),
		.intensity (intensity)
	);

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable(light_x_q) && $stable(light_y_q))
		else $error("light position changed without a configuration write");

endmodule

// ----- rtl/bmps_slope.sv -----
module bmps_slope #(
	parameter int SCREEN_WIDTH  = bmps_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bmps_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [7:0]          height_left,
	input  logic [7:0]          height_right,
	input  logic [7:0]          height_above,
	input  logic [7:0]          height_below,
	input  logic [8:0]          pixel_col,
	input  logic [7:0]          pixel_row,
	input  logic [8:0]          light_x,
	input  logic [7:0]          light_y,
	output logic                valid_s1,
	output bmps_pkg::slope_t    slope_s1
);

	localparam logic [12:0] COL_LIMIT = 13'(SCREEN_WIDTH);
	localparam logic [12:0] ROW_LIMIT = 13'(SCREEN_HEIGHT - 1);

	logic signed [10:0] u_raw;
	logic signed [10:0] v_raw;
	logic [7:0]         u_clip;
	logic [7:0]         v_clip;
	logic               on_screen;
	bmps_pkg::slope_t   slope_d;

	assign u_raw = $signed({3'b000, height_left}) - $signed({3'b000, height_right})
		- $signed({2'b00, pixel_col}) + $signed({2'b00, light_x})
		+ $signed({3'b000, bmps_pkg::COORD_BIAS});
	assign v_raw = $signed({3'b000, height_above}) - $signed({3'b000, height_below})
		- $signed({3'b000, pixel_row}) + $signed({3'b000, light_y})
		+ $signed({3'b000, bmps_pkg::COORD_BIAS});

	// A coordinate outside 0..255 falls back to zero.
	assign u_clip = (u_raw[10:8] == 3'b000) ? u_raw[7:0] : 8'd0;
	assign v_clip = (v_raw[10:8] == 3'b000) ? v_raw[7:0] : 8'd0;

	assign on_screen = (pixel_row != 8'd0) && ({5'b0, pixel_row} < ROW_LIMIT)
		&& ({4'b0, pixel_col} < COL_LIMIT);

	always_comb begin
		slope_d.on_screen = on_screen;
		slope_d.dx        = $signed(u_clip - bmps_pkg::COORD_BIAS);
		slope_d.dy        = $signed(v_clip - bmps_pkg::COORD_BIAS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slope_s1 <= slope_d;
		end
	end

	a_border_row_dark: assert property (@(posedge clk) disable iff (!arst_n)
		en && in_valid && (pixel_row == 8'd0) |=> valid_s1 && !slope_s1.on_screen)
		else $error("top row was not marked as outside the screen");

endmodule

// ----- rtl/bmps_radius.sv -----
module bmps_radius (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_s1,
	input  bmps_pkg::slope_t            slope_s1,
	output logic                        valid_s3,
	output logic [bmps_pkg::LHS_W-1:0]  lhs_s3
);

	logic signed [15:0]          dx_sq;
	logic signed [15:0]          dy_sq;
	logic [15:0]                 r2_d;
	logic                        valid_s2;
	logic                        inside_s2;
	logic [15:0]                 r2_s2;
	logic [27:0]                 lhs_prod;
	logic [bmps_pkg::LHS_W-1:0]  lhs_d;

	assign dx_sq = slope_s1.dx * slope_s1.dx;
	assign dy_sq = slope_s1.dy * slope_s1.dy;
	assign r2_d  = $unsigned(dx_sq) + $unsigned(dy_sq);

	assign lhs_prod = {12'd0, r2_s2} * {16'd0, bmps_pkg::ENV_SCALE};
	// Pixels off the screen get a left-hand side no disc radius can meet.
	assign lhs_d = inside_s2 ? lhs_prod[bmps_pkg::LHS_W-1:0] : '1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s2 <= slope_s1.on_screen;
			r2_s2     <= r2_d;
			lhs_s3    <= lhs_d;
		end
	end

	a_r2_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (r2_s2 <= 16'd32768))
		else $error("squared radius beyond the coordinate range");

endmodule

// ----- rtl/bmps_search.sv -----
module bmps_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_s3,
	input  logic [bmps_pkg::LHS_W-1:0]  lhs_s3,
	output logic                        out_valid,
	output logic [bmps_pkg::K_W-1:0]    intensity
);

	localparam int STEPS = bmps_pkg::K_W;

	logic                        valid_s [STEPS];
	logic [bmps_pkg::K_W-1:0]    k_s     [STEPS];
	logic [bmps_pkg::LHS_W-1:0]  lhs_s   [STEPS];

	// One bit of k is settled per stage, most significant bit first.
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [bmps_pkg::K_W-1:0] TRY_BIT =
			bmps_pkg::K_W'(1) << (bmps_pkg::K_W - 1 - j);

		logic                        valid_p;
		logic [bmps_pkg::K_W-1:0]    k_p;
		logic [bmps_pkg::LHS_W-1:0]  lhs_p;
		logic [bmps_pkg::K_W-1:0]    trial;
		logic [bmps_pkg::K_W-1:0]    comp;
		logic [2*bmps_pkg::K_W-1:0]  comp_sq;
		logic [bmps_pkg::LHS_W-1:0]  rhs;

		if (j == 0) begin : g_first
			assign valid_p = valid_s3;
			assign k_p     = '0;
			assign lhs_p   = lhs_s3;
		end else begin : g_next
			assign valid_p = valid_s[j-1];
			assign k_p     = k_s[j-1];
			assign lhs_p   = lhs_s[j-1];
		end

		assign trial   = k_p | TRY_BIT;
		assign comp    = bmps_pkg::MAX_K - trial;
		assign comp_sq = comp * comp;
		assign rhs     = bmps_pkg::LHS_W'({comp_sq, bmps_pkg::RHS_SHIFT'(0)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= valid_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				k_s[j]   <= (lhs_p <= rhs) ? trial : k_p;
				lhs_s[j] <= lhs_p;
			end
		end
	end

	assign out_valid = valid_s[STEPS-1];
	assign intensity = k_s[STEPS-1];

	a_off_disc_dark: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[STEPS-1] && (lhs_s[STEPS-1] > bmps_pkg::DISC_LHS)
		|-> (k_s[STEPS-1] == '0))
		else $error("pixel off the light disc produced nonzero intensity");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the bump-mapped pixel shader core.
//
// A queue of pending pixels is filled by the stimulus process. A clocked driver
// offers them on the input channel in bursts with random gaps. Every accepted
// pixel is shaded right away by the testbench's own intensity predictor, which
// uses the light position that the testbench last wrote. The predicted value is
// queued. A clocked monitor stalls the output channel in a pattern of its own,
// and it compares each accepted intensity beat with the oldest prediction.
module tb;

	localparam int CLK_HALF      = 6;
	localparam int PIPE_LATENCY  = 9;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int LONG_HOLD     = 120;
	localparam int SCREEN_W      = bmps_pkg::SCREEN_WIDTH_DEF;
	localparam int SCREEN_H      = bmps_pkg::SCREEN_HEIGHT_DEF;

	// Indexes that the core does not decode. Writes to them must change nothing.
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] above;
		logic [7:0] below;
		logic [8:0] col;
		logic [7:0] row;
	} pixel_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] height_left  = '0;
	logic [7:0] height_right = '0;
	logic [7:0] height_above = '0;
	logic [7:0] height_below = '0;
	logic [8:0] pixel_col    = '0;
	logic [7:0] pixel_row    = '0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [5:0] intensity;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index    = '0;
	logic [8:0] cfg_data     = '0;

	// The light position as the core should hold it.
	logic [8:0] light_x_now = bmps_pkg::LIGHT_X_RESET;
	logic [7:0] light_y_now = bmps_pkg::LIGHT_Y_RESET;

	pixel_t     pending_pixels[$];
	logic [5:0] shade_expect[$];
	int         mismatches = 0;
	int         cycle_count = 0;

	bump_map_pixel_shader_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.height_left  (height_left),
		.height_right (height_right),
		.height_above (height_above),
		.height_below (height_below),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.intensity    (intensity),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// A slope coordinate is the height difference plus the light offset, biased
	// to the middle of 0..255. Anything outside that range collapses to zero.
	function automatic int slope_coord(int a, int b, int pos, int light);
		int c;
		c = a - b - pos + light + 128;
		if (c < 0 || c > 255) begin
			c = 0;
		end
		return c;
	endfunction

	// Radial environment light: the brightest level k whose ring still holds the
	// point, found by comparing 3969 * r2 with 16384 * (63 - k) squared.
	function automatic logic [5:0] shade_pixel(pixel_t p, logic [8:0] lx, logic [7:0] ly);
		int dx;
		int dy;
		int r2;
		if (p.row == 0 || int'(p.row) >= SCREEN_H - 1 || int'(p.col) >= SCREEN_W) begin
			return '0;
		end
		dx = slope_coord(p.left, p.right, p.col, lx) - 128;
		dy = slope_coord(p.above, p.below, p.row, ly) - 128;
		r2 = dx * dx + dy * dy;
		for (int d = 0; d <= 63; d++) begin
			if (16384 * d * d >= 3969 * r2) begin
				return 6'(63 - d);
			end
		end
		return '0;
	endfunction

	// Driver. A beat is held while it is stalled. Otherwise the next pixel goes
	// out, unless the current burst has ended and its gap is still running.
	int     burst_left = 0;
	int     gap_left = 0;
	pixel_t offered = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				shade_expect.push_back(shade_pixel(offered, light_x_now, light_y_now));
			end
			if (burst_left == 0 && gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_pixels.size() != 0) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
				end
				offered = pending_pixels.pop_front();
				height_left  <= offered.left;
				height_right <= offered.right;
				height_above <= offered.above;
				height_below <= offered.below;
				pixel_col    <= offered.col;
				pixel_row    <= offered.row;
				in_valid     <= 1'b1;
				burst_left--;
				if (burst_left == 0) begin
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor. Every accepted intensity beat is checked against the oldest
	// prediction. The stall pattern alternates short stalls with free runs of
	// mixed length, and twice in the run the receiver holds off long enough for
	// the pipe to fill and push back on the input channel.
	int   results_seen = 0;
	int   long_hold_left = 0;
	int   stall_run_left = 0;
	logic stalling = 1'b1;

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (shade_expect.size() == 0) begin
				$error("intensity: beat %0d arrived with no pixel pending", intensity);
				mismatches++;
			end else if (shade_expect[0] !== intensity) begin
				$error("intensity: expected %0d, actual %0d", shade_expect[0], intensity);
				mismatches++;
				void'(shade_expect.pop_front());
			end else begin
				void'(shade_expect.pop_front());
			end
			results_seen++;
			if (results_seen == 150 || results_seen == 800) begin
				long_hold_left = LONG_HOLD;
			end
		end
		if (long_hold_left != 0) begin
			long_hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stall_run_left == 0) begin
				stalling = !stalling;
				if (stalling) begin
					stall_run_left = $urandom_range(1, 4);
				end else if ($urandom_range(0, 3) == 0) begin
					stall_run_left = $urandom_range(40, 80);
				end else begin
					stall_run_left = $urandom_range(1, 12);
				end
			end
			stall_run_left--;
			out_stall <= stalling;
		end
	end

	// The whole run is bounded. A hang anywhere ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_pixel(int l, int r, int a, int b, int c, int rw);
		pixel_t p;
		p.left  = 8'(l);
		p.right = 8'(r);
		p.above = 8'(a);
		p.below = 8'(b);
		p.col   = 9'(c);
		p.row   = 8'(rw);
		pending_pixels.push_back(p);
	endtask

	// Picks two height bytes whose difference lands the slope coordinate near a
	// random target, so that most pixels fall on the light disc.
	task automatic aim_heights(int pos, int light, output logic [7:0] hi, output logic [7:0] lo);
		int diff;
		diff = $urandom_range(0, 255) - 128 + pos - light;
		if (diff > 255) begin
			diff = 255;
		end else if (diff < -255) begin
			diff = -255;
		end
		if (diff >= 0) begin
			lo = 8'($urandom_range(0, 255 - diff));
			hi = 8'(int'(lo) + diff);
		end else begin
			hi = 8'($urandom_range(0, 255 + diff));
			lo = 8'(int'(hi) - diff);
		end
	endtask

	// Random pixels: mostly on screen and aimed at the disc, some off screen or
	// on the border rows, and some with every field fully random.
	task automatic add_random_pixels(int count);
		pixel_t p;
		int     pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				p = pixel_t'(49'({$urandom, $urandom}));
			end else if (pick < 22) begin
				p = pixel_t'(49'({$urandom, $urandom}));
				case ($urandom_range(0, 3))
					0: p.row = '0;
					1: p.row = 8'(SCREEN_H - 1);
					2: p.row = 8'($urandom_range(SCREEN_H, 255));
					default: begin
						p.row = 8'($urandom_range(1, SCREEN_H - 2));
						p.col = 9'($urandom_range(SCREEN_W, 511));
					end
				endcase
			end else begin
				p.row = 8'($urandom_range(1, SCREEN_H - 2));
				p.col = 9'($urandom_range(0, SCREEN_W - 1));
				aim_heights(p.col, light_x_now, p.left, p.right);
				aim_heights(p.row, light_y_now, p.above, p.below);
			end
			pending_pixels.push_back(p);
		end
	endtask

	// Returns once every queued pixel has been accepted and every prediction
	// has been matched by a beat.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_pixels.size() != 0 || in_valid || shade_expect.size() != 0);
	endtask

	// Register writes happen only while the pipe is empty, so the new light
	// position applies to every pixel accepted after the write.
	task automatic write_reg(logic [1:0] idx, logic [8:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			bmps_pkg::CFG_LIGHT_X: light_x_now = data;
			bmps_pkg::CFG_LIGHT_Y: light_y_now = data[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic next_setting(logic [8:0] lx, logic [7:0] ly, int count);
		wait_drained();
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		write_reg(bmps_pkg::CFG_LIGHT_X, lx);
		write_reg(bmps_pkg::CFG_LIGHT_Y, 9'(ly));
		@(negedge clk);
		add_random_pixels(count);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pixels under the reset light position (160, 100).
		add_pixel(50, 50, 70, 70, 160, 100);    // dead center of the disc
		add_pixel(10, 20, 30, 40, 160, 0);      // first row
		add_pixel(10, 20, 30, 40, 160, 199);    // last row
		add_pixel(10, 20, 30, 40, 160, 200);    // row just below the screen
		add_pixel(10, 20, 30, 40, 511, 255);    // both past the screen
		add_pixel(10, 20, 30, 40, 320, 100);    // column just right of the screen
		add_pixel(10, 20, 30, 40, 511, 1);
		add_pixel(0, 0, 0, 0, 319, 198);        // last on-screen corner
		add_pixel(255, 0, 255, 0, 0, 1);        // both coordinates overflow
		add_pixel(0, 255, 90, 90, 10, 100);     // steepest falling slope
		add_pixel(0, 33, 7, 7, 0, 100);         // u exactly 255
		add_pixel(0, 0, 7, 7, 288, 100);        // u exactly 0, on the disc edge
		add_pixel(0, 0, 7, 7, 289, 100);        // u of -1 falls back to zero
		add_pixel(0, 32, 7, 7, 0, 100);         // u of 256 wraps to zero
		add_pixel(3, 3, 255, 0, 160, 1);        // v overflows
		add_pixel(3, 3, 28, 0, 160, 1);         // v exactly 255
		add_pixel(9, 9, 4, 4, 159, 100);        // one step off center
		add_pixel(9, 9, 4, 4, 287, 100);        // just inside the disc edge
		add_pixel(9, 9, 4, 4, 250, 190);        // diagonal point
		add_pixel(255, 255, 255, 255, 511, 255);
		add_pixel(0, 0, 0, 0, 0, 0);
		add_random_pixels(200);

		// Extremes of the light registers, then spare indexes, then random ones.
		next_setting('0, '0, 230);
		next_setting(9'(SCREEN_W - 1), 8'(SCREEN_H - 1), 230);
		next_setting('1, '1, 200);
		wait_drained();
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		write_reg(CFG_SPARE_A, 9'($urandom));
		write_reg(CFG_SPARE_B, 9'($urandom));
		next_setting(9'($urandom_range(0, SCREEN_W - 1)),
			8'($urandom_range(0, SCREEN_H - 1)), 250);
		next_setting(9'($urandom), 8'($urandom), 250);

		wait_drained();
		repeat (PIPE_LATENCY * 3) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/bmps_pkg.sv
rtl/bmps_slope.sv
rtl/bmps_radius.sv
rtl/bmps_search.sv
rtl/bump_map_pixel_shader_core.sv
test/tb.sv
